### sv/ppi_pkg.sv
// Package for the positional and incremental PID core.
// Holds field widths, register indexes and the struct types shared by all modules.
// Depends on nothing.
package ppi_pkg;

	localparam int GAIN_FRAC_BITS = 8;
	localparam int PROD_W = 40;
	localparam int TERM_W = 42;
	localparam int RAW_W = 43;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_MODE_INCREMENTAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_MAX = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_MIN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MAX = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MIN = 3'd7;

	typedef struct packed {
		logic        action;
		logic [15:0] measured;
		logic [15:0] target;
	} sample_t;

	typedef struct packed {
		logic [15:0] drive;
		logic        clamped;
	} result_t;

	typedef struct packed {
		logic               mode_incremental;
		logic signed [15:0] gain_p;
		logic signed [15:0] gain_i;
		logic signed [15:0] gain_d;
		logic signed [23:0] integral_max;
		logic signed [23:0] integral_min;
		logic [15:0]        output_max;
		logic [15:0]        output_min;
	} cfg_t;

	typedef struct packed {
		logic               clear;
		logic               incremental;
		logic signed [16:0] e;
		logic signed [17:0] d1;
		logic signed [18:0] d2;
		logic signed [23:0] s;
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef struct packed {
		logic        b1_valid;
		logic        b2_valid;
		logic [15:0] held;
	} back_status_t;

endpackage

### sv/ppi_front.sv
// Front end of the PID core: accepts samples, forms the error terms and the
// clamped error sum, and pushes one work item per sample into the queue.
// Depends on ppi_pkg.
module ppi_front (
	input  logic             clk,
	input  logic             arst_n,
	input  ppi_pkg::cfg_t    cfg,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  ppi_pkg::sample_t sample,
	input  logic             full,
	output logic             push_valid,
	output ppi_pkg::work_t   push_item
);

	logic signed [16:0] last_q;
	logic signed [16:0] prior_q;
	logic signed [23:0] sum_q;
	logic signed [16:0] e;
	logic signed [24:0] s_raw;
	logic signed [24:0] s_hi;
	logic signed [24:0] s_lo;
	logic signed [23:0] s_new;
	logic               accept;

	assign sample_stall = full;
	assign accept = sample_valid && !full;
	assign push_valid = accept;

	always_comb begin
		e = $signed({1'b0, sample.target}) - $signed({1'b0, sample.measured});
		s_raw = 25'(sum_q) + 25'(e);
		s_hi = (s_raw >= 25'(cfg.integral_max)) ? 25'(cfg.integral_max) : s_raw;
		s_lo = (s_hi <= 25'(cfg.integral_min)) ? 25'(cfg.integral_min) : s_hi;
		s_new = s_lo[23:0];
		push_item.clear = sample.action;
		push_item.incremental = cfg.mode_incremental;
		push_item.e = e;
		push_item.d1 = 18'(e) - 18'(last_q);
		push_item.d2 = 19'(e) - (19'(last_q) <<< 1) + 19'(prior_q);
		push_item.s = s_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			prior_q <= '0;
			sum_q <= '0;
		end else if (accept) begin
			if (sample.action) begin
				last_q <= '0;
				prior_q <= '0;
				sum_q <= '0;
			end else begin
				prior_q <= last_q;
				last_q <= e;
				if (!cfg.mode_incremental) begin
					sum_q <= s_new;
				end
			end
		end
	end

endmodule

### sv/ppi_queue.sv
// Short register queue between the front end and the back end of the PID core.
// Lets either side stall without holding up the other.
// Depends on ppi_pkg.
module ppi_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	input  ppi_pkg::work_t        push_item,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output ppi_pkg::work_t        pop_item,
	output ppi_pkg::queue_status_t status
);

	ppi_pkg::work_t mem_q [ppi_pkg::QUEUE_DEPTH];
	logic [ppi_pkg::QUEUE_AW-1:0] wr_q;
	logic [ppi_pkg::QUEUE_AW-1:0] rd_q;
	logic [ppi_pkg::QUEUE_AW:0]   cnt_q;
	logic                         push;
	logic                         pop;

	assign status.full = (cnt_q == (ppi_pkg::QUEUE_AW+1)'(ppi_pkg::QUEUE_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign push = push_valid && !status.full;
	assign pop = pop_ready && !status.empty;
	assign pop_valid = !status.empty;
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### sv/ppi_back.sv
// Back end of the PID core: three gain products, the shifted term sum, and
// the output clamp with the held output, ending in the result register.
// Depends on ppi_pkg.
module ppi_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ppi_pkg::cfg_t         cfg,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  ppi_pkg::work_t        pop_item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output ppi_pkg::result_t      result,
	output ppi_pkg::back_status_t status
);

	localparam int PW = ppi_pkg::PROD_W;
	localparam int TW = ppi_pkg::TERM_W;
	localparam int RW = ppi_pkg::RAW_W;
	localparam int F = ppi_pkg::GAIN_FRAC_BITS;

	logic                 b1_valid_s1;
	logic                 clear_s1;
	logic                 inc_s1;
	logic signed [PW-1:0] p_s1;
	logic signed [PW-1:0] i_s1;
	logic signed [PW-1:0] d_s1;
	logic                 b2_valid_s2;
	logic                 clear_s2;
	logic                 inc_s2;
	logic signed [TW-1:0] t_s2;
	logic                 result_valid_q;
	ppi_pkg::result_t     result_q;
	logic [15:0]          held_q;

	logic                 en_out;
	logic                 en_b2;
	logic                 en_b1;
	logic signed [23:0]   op_p;
	logic signed [23:0]   op_i;
	logic signed [23:0]   op_d;
	logic signed [RW-1:0] raw;
	logic signed [RW-1:0] res_hi;
	logic signed [RW-1:0] res;
	logic signed [RW-1:0] omax_x;
	logic signed [RW-1:0] omin_x;

	assign en_out = !result_valid_q || !result_stall;
	assign en_b2 = !b2_valid_s2 || en_out;
	assign en_b1 = !b1_valid_s1 || en_b2;
	assign pop_ready = en_b1;

	always_comb begin
		if (pop_item.incremental) begin
			op_p = 24'(pop_item.d1);
			op_i = 24'(pop_item.e);
			op_d = 24'(pop_item.d2);
		end else begin
			op_p = 24'(pop_item.e);
			op_i = pop_item.s;
			op_d = 24'(pop_item.d1);
		end
		omax_x = $signed(RW'(cfg.output_max));
		omin_x = $signed(RW'(cfg.output_min));
		raw = RW'(t_s2) + (inc_s2 ? $signed(RW'(held_q)) : RW'(0));
		res_hi = (raw >= omax_x) ? omax_x : raw;
		res = (res_hi <= omin_x) ? omin_x : res_hi;
	end

	always_ff @(posedge clk) begin
		if (en_b1) begin
			clear_s1 <= pop_item.clear;
			inc_s1 <= pop_item.incremental;
			p_s1 <= PW'(cfg.gain_p) * PW'(op_p);
			i_s1 <= PW'(cfg.gain_i) * PW'(op_i);
			d_s1 <= PW'(cfg.gain_d) * PW'(op_d);
		end
		if (en_b2) begin
			clear_s2 <= clear_s1;
			inc_s2 <= inc_s1;
			t_s2 <= TW'(p_s1 >>> F) + TW'(i_s1 >>> F) + TW'(d_s1 >>> F);
		end
		if (en_out && b2_valid_s2) begin
			result_q.drive <= res[15:0];
			result_q.clamped <= (res != raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_valid_s1 <= 1'b0;
			b2_valid_s2 <= 1'b0;
			result_valid_q <= 1'b0;
			held_q <= '0;
		end else begin
			if (en_b1) begin
				b1_valid_s1 <= pop_valid;
			end
			if (en_b2) begin
				b2_valid_s2 <= b1_valid_s1;
			end
			if (en_out) begin
				result_valid_q <= b2_valid_s2 && !clear_s2;
				if (b2_valid_s2) begin
					held_q <= clear_s2 ? 16'd0 : res[15:0];
				end
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;
	assign status.b1_valid = b1_valid_s1;
	assign status.b2_valid = b2_valid_s2;
	assign status.held = held_q;

endmodule

### sv/pid_position_incremental_core.sv
// PID controller core with positional and incremental forms.
// A sample transaction carries action, measured and target. A run action gives
// one result transaction with drive and clamped; a clear action zeroes the error
// history, the error sum and the held output and gives no result.
// Configuration is written through cfg_valid, cfg_ready, cfg_index and cfg_data,
// one register per transaction; cfg_ready is always high. Registers must be
// written only while no sample is in flight; the block does not enforce it.
// An accepted sample goes through the queue, the product stage, the term-sum
// stage and the result register to result_valid. One sample is taken per cycle
// while sample_stall is low; the rate is set by the held-output add and clamp,
// which closes its loop in the last stage, and by the front-end error-sum clamp.
// A four-entry queue sits between the front end and the multiplier stages.
// When the receiver stalls, the result register holds its transaction, the
// stages behind it fill, then the queue fills and sample_stall rises.
// Reset clears all loop state, empties the queue and the pipeline, and loads
// the configuration registers with their reset values.
module pid_position_incremental_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  ppi_pkg::sample_t                   sample,
	output logic                               result_valid,
	input  logic                               result_stall,
	output ppi_pkg::result_t                   result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ppi_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ppi_pkg::CFG_DATA_W-1:0]     cfg_data
);

	ppi_pkg::cfg_t          cfg_q;
	ppi_pkg::work_t         push_item;
	ppi_pkg::work_t         pop_item;
	ppi_pkg::queue_status_t q_status;
	ppi_pkg::back_status_t  b_status;
	logic                   push_valid;
	logic                   pop_valid;
	logic                   pop_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_incremental <= 1'b0;
			cfg_q.gain_p <= '0;
			cfg_q.gain_i <= '0;
			cfg_q.gain_d <= '0;
			cfg_q.integral_max <= 24'sh7FFFFF;
			cfg_q.integral_min <= 24'sh800000;
			cfg_q.output_max <= 16'hFFFF;
			cfg_q.output_min <= 16'h0000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ppi_pkg::REG_MODE_INCREMENTAL: cfg_q.mode_incremental <= cfg_data[0];
				ppi_pkg::REG_GAIN_P: cfg_q.gain_p <= cfg_data[15:0];
				ppi_pkg::REG_GAIN_I: cfg_q.gain_i <= cfg_data[15:0];
				ppi_pkg::REG_GAIN_D: cfg_q.gain_d <= cfg_data[15:0];
				ppi_pkg::REG_INTEGRAL_MAX: cfg_q.integral_max <= cfg_data;
				ppi_pkg::REG_INTEGRAL_MIN: cfg_q.integral_min <= cfg_data;
				ppi_pkg::REG_OUTPUT_MAX: cfg_q.output_max <= cfg_data[15:0];
				ppi_pkg::REG_OUTPUT_MIN: cfg_q.output_min <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	ppi_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.full         (q_status.full),
		.push_valid   (push_valid),
		.push_item    (push_item)
	);

	ppi_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item),
		.status     (q_status)
	);

	ppi_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_item     (pop_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.status       (b_status)
	);

`ifndef SYNTH
	a_held_matches_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (b_status.held == result.drive))
		else $error("Held output differs from the pending result.");

	a_queue_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("Queue reports full and empty at once.");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall && b_status.b2_valid) |=> b_status.b2_valid)
		else $error("Stage two lost its transaction while the result was stalled.");
`endif

endmodule
